// ----- sv/c2d_pkg.sv -----
// c2d_pkg: shared types and constants of the convolution engine
// no dependencies
`default_nettype none
package c2d_pkg;
  localparam int unsigned NUM_REGS = 7;

  typedef enum logic [1:0] {
    OP_LOAD_SAMPLE = 2'd0,
    OP_LOAD_WEIGHT = 2'd1,
    OP_LOAD_BIAS   = 2'd2,
    OP_COMPUTE     = 2'd3
  } opcode_t;

  localparam logic [2:0] REG_IN_HEIGHT    = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH     = 3'd1;
  localparam logic [2:0] REG_IN_CHANNELS  = 3'd2;
  localparam logic [2:0] REG_OUT_CHANNELS = 3'd3;
  localparam logic [2:0] REG_KERNEL_SIDE  = 3'd4;
  localparam logic [2:0] REG_STRIDE       = 3'd5;
  localparam logic [2:0] REG_PADDING      = 3'd6;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         out_channel;
    logic [2:0]         in_channel;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] conv_value;
    logic               status;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } back_state_t;
endpackage
`default_nettype wire

// ----- sv/c2d_queue.sv -----
// c2d_queue: small fifo of input items between front and back
// depends on c2d_pkg
`default_nettype none
module c2d_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  c2d_pkg::in_item_t   push_item,
  input  wire                 pop,
  output c2d_pkg::in_item_t   head_item,
  output logic                not_empty,
  output logic                full
);
  import c2d_pkg::*;
  in_item_t    mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign not_empty = cnt_r != 2'd0;
  assign full = cnt_r == 2'd2;
  assign head_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push || pop)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
endmodule
`default_nettype wire

// ----- sv/c2d_back.sv -----
// c2d_back: stores and multiply-accumulate sequencer of the engine
// depends on c2d_pkg
`default_nettype none
module c2d_back #(
  parameter int MAX_IN_CH  = 8,
  parameter int MAX_OUT_CH = 8,
  parameter int MAX_DIM    = 32,
  parameter int MAX_K      = 7
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 item_valid,
  input  c2d_pkg::in_item_t   item,
  output logic                item_pop,
  input  wire  [5:0]          h_cfg,
  input  wire  [5:0]          w_cfg,
  input  wire  [3:0]          nic_cfg,
  input  wire  [3:0]          noc_cfg,
  input  wire  [2:0]          k_cfg,
  input  wire  [2:0]          s_cfg,
  input  wire  [1:0]          p_cfg,
  output logic                out_valid,
  output c2d_pkg::out_item_t  out_item
);
  import c2d_pkg::*;
  localparam int OCW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int SDEPTH = MAX_IN_CH * MAX_DIM * MAX_DIM;
  localparam int WDEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_K * MAX_K;
  localparam int SAW = $clog2(SDEPTH);
  localparam int WAW = $clog2(WDEPTH);
  localparam int CW = 12;

  logic [15:0] sample_mem [SDEPTH];
  logic [15:0] weight_mem [WDEPTH];
  logic [31:0] bias_mem   [MAX_OUT_CH];

  back_state_t state_r, state_nxt;
  logic [CW-1:0] h_r, w_r, nic_r, k_r, p_r;
  logic [OCW-1:0] oc_r;
  logic [CW-1:0] c_r, kr_r, kc_r, base_r_r, base_c_r;
  logic signed [47:0] acc_r;
  logic signed [31:0] bias_r;
  logic signed [15:0] smp_r, wgt_r;
  logic take_r;
  logic signed [31:0] prod_r;
  logic prod_v_r;
  logic out_valid_r;
  out_item_t out_item_r;

  // clamped configuration
  logic [CW-1:0] h_c, w_c, nic_c, noc_c, k_c, s_c, p_c, oh_c, ow_c, span_h, span_w;
  always_comb begin
    h_c = (h_cfg == 6'd0) ? CW'(1) : ((CW'(h_cfg) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(h_cfg));
    w_c = (w_cfg == 6'd0) ? CW'(1) : ((CW'(w_cfg) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(w_cfg));
    nic_c = (nic_cfg == 4'd0) ? CW'(1) :
            ((CW'(nic_cfg) > CW'(MAX_IN_CH)) ? CW'(MAX_IN_CH) : CW'(nic_cfg));
    noc_c = (noc_cfg == 4'd0) ? CW'(1) :
            ((CW'(noc_cfg) > CW'(MAX_OUT_CH)) ? CW'(MAX_OUT_CH) : CW'(noc_cfg));
    k_c = (k_cfg == 3'd0) ? CW'(1) : ((CW'(k_cfg) > CW'(MAX_K)) ? CW'(MAX_K) : CW'(k_cfg));
    s_c = (s_cfg == 3'd0) ? CW'(1) : ((s_cfg > 3'd4) ? CW'(4) : CW'(s_cfg));
    p_c = CW'(p_cfg);
    span_h = h_c + (p_c << 1);
    span_w = w_c + (p_c << 1);
    oh_c = '0;
    ow_c = '0;
    // small quotient by stride, values below 2^9
    case (s_c[2:0])
      3'd1: begin
        if (span_h >= k_c) oh_c = span_h - k_c + CW'(1);
        if (span_w >= k_c) ow_c = span_w - k_c + CW'(1);
      end
      3'd2: begin
        if (span_h >= k_c) oh_c = ((span_h - k_c) >> 1) + CW'(1);
        if (span_w >= k_c) ow_c = ((span_w - k_c) >> 1) + CW'(1);
      end
      3'd4: begin
        if (span_h >= k_c) oh_c = ((span_h - k_c) >> 2) + CW'(1);
        if (span_w >= k_c) ow_c = ((span_w - k_c) >> 2) + CW'(1);
      end
      default: begin
        if (span_h >= k_c) oh_c = CW'(((24'(span_h - k_c)) * 24'd683) >> 11) + CW'(1);
        if (span_w >= k_c) ow_c = CW'(((24'(span_w - k_c)) * 24'd683) >> 11) + CW'(1);
      end
    endcase
  end

  logic is_cmp, bad;
  assign is_cmp = item_valid && (item.opcode == OP_COMPUTE);
  assign bad = (CW'(item.out_channel) >= noc_c) || (CW'(item.row) >= oh_c) ||
               (CW'(item.col) >= ow_c);

  // stores
  always_ff @(posedge clk) begin
    if (item_valid && state_r == ST_IDLE) begin
      if (item.opcode == OP_LOAD_SAMPLE && 32'(item.in_channel) < MAX_IN_CH &&
          32'(item.row) < MAX_DIM && 32'(item.col) < MAX_DIM)
        sample_mem[SAW'((32'(item.in_channel) * MAX_DIM + 32'(item.row)) * MAX_DIM +
                        32'(item.col))] <= item.value[15:0];
      if (item.opcode == OP_LOAD_WEIGHT && 32'(item.out_channel) < MAX_OUT_CH &&
          32'(item.in_channel) < MAX_IN_CH && 32'(item.row) < MAX_K && 32'(item.col) < MAX_K)
        weight_mem[WAW'(((32'(item.out_channel) * MAX_IN_CH + 32'(item.in_channel)) * MAX_K +
                         32'(item.row)) * MAX_K + 32'(item.col))] <= item.value[15:0];
      if (item.opcode == OP_LOAD_BIAS && 32'(item.out_channel) < MAX_OUT_CH)
        bias_mem[OCW'(item.out_channel)] <= item.value;
    end
  end

  // tap position
  logic [CW-1:0] ir, icl;
  logic tap_in;
  assign ir = base_r_r + kr_r;
  assign icl = base_c_r + kc_r;
  assign tap_in = (ir >= p_r) && (ir - p_r < h_r) && (icl >= p_r) && (icl - p_r < w_r);

  always_ff @(posedge clk) begin
    smp_r <= sample_mem[SAW'((32'(c_r) * MAX_DIM + 32'(ir - p_r)) * MAX_DIM + 32'(icl - p_r))];
    wgt_r <= weight_mem[WAW'(((32'(oc_r) * MAX_IN_CH + 32'(c_r)) * MAX_K + 32'(kr_r)) * MAX_K +
                             32'(kc_r))];
  end

  logic last_tap;
  assign last_tap = (kc_r == k_r - CW'(1)) && (kr_r == k_r - CW'(1)) &&
                    (c_r == nic_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    item_pop = 1'b0;
    case (state_r)
      ST_IDLE: if (item_valid) begin
        item_pop = 1'b1;
        if (is_cmp && !bad) state_nxt = ST_RUN;
      end
      ST_RUN: if (last_tap) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!take_r && !prod_v_r) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic signed [47:0] rnd;
  logic signed [48:0] tot;
  assign rnd = (acc_r + 48'sd2048) >>> 12;
  assign tot = 49'(rnd) + 49'(bias_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      take_r <= 1'b0;
      prod_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      take_r <= (state_r == ST_RUN) && tap_in;
      prod_v_r <= take_r;
      out_valid_r <= (state_r == ST_DONE) || (state_r == ST_IDLE && is_cmp && bad);
    end
  end

  always_ff @(posedge clk) begin
    if (take_r) prod_r <= smp_r * wgt_r;
    if (state_r == ST_IDLE) begin
      h_r <= h_c; w_r <= w_c; nic_r <= nic_c; k_r <= k_c; p_r <= p_c;
      oc_r <= OCW'(item.out_channel);
      base_r_r <= CW'(item.row) * s_c;
      base_c_r <= CW'(item.col) * s_c;
      c_r <= '0; kr_r <= '0; kc_r <= '0;
      acc_r <= '0;
      bias_r <= bias_mem[OCW'(item.out_channel)];
    end else begin
      if (state_r == ST_RUN) begin
        if (kc_r == k_r - CW'(1)) begin
          kc_r <= '0;
          if (kr_r == k_r - CW'(1)) begin
            kr_r <= '0;
            c_r <= c_r + CW'(1);
          end else kr_r <= kr_r + CW'(1);
        end else kc_r <= kc_r + CW'(1);
      end
      if (prod_v_r) acc_r <= acc_r + 48'(prod_r);
    end
    if (state_r == ST_DONE) begin
      out_item_r.status <= 1'b0;
      if (tot > 49'sd2147483647) out_item_r.conv_value <= 32'sh7fffffff;
      else if (tot < -49'sd2147483648) out_item_r.conv_value <= 32'sh80000000;
      else out_item_r.conv_value <= tot[31:0];
    end else if (state_r == ST_IDLE) begin
      out_item_r.status <= 1'b1;
      out_item_r.conv_value <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> state_r == ST_IDLE) else $error("pop while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == ST_DONE) |-> out_valid) else $error("missing result");
  a_no_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !take_r || $past(state_r) != ST_IDLE)
    else $error("stray tap");
endmodule
`default_nettype wire

// ----- sv/conv2d_forward_engine.sv -----
// conv2d_forward_engine: top level, front end with config registers and queue
// depends on c2d_pkg, c2d_queue, c2d_back
`default_nettype none
// Load items, and compute items outside the output grid or channel range,
// leave the queue once at its head while idle. A compute item in the grid
// steps through in_channels*k*k taps, k being the kernel side, one tap a
// cycle via the sample and weight memory ports, then drains and registers
// its result. The queue holds two items; busy is high while it is full.
// Results appear for one cycle on out_valid and must be taken then.
// Configuration must be written only while idle, unenforced by the block.
module conv2d_forward_engine #(
  parameter int MAX_IN_CH  = 8,
  parameter int MAX_OUT_CH = 8,
  parameter int MAX_DIM    = 32,
  parameter int MAX_K      = 7
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  c2d_pkg::in_item_t   in_item,
  output logic                out_valid,
  output c2d_pkg::out_item_t  out_item,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_index,
  input  wire  [5:0]          cfg_data
);
  import c2d_pkg::*;
  logic [5:0] h_r, w_r;
  logic [3:0] nic_r, noc_r;
  logic [2:0] k_r, s_r;
  logic [1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= 6'd32; w_r <= 6'd32; nic_r <= 4'd1; noc_r <= 4'd1;
      k_r <= 3'd3; s_r <= 3'd1; p_r <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_HEIGHT:    h_r <= cfg_data;
        REG_IN_WIDTH:     w_r <= cfg_data;
        REG_IN_CHANNELS:  nic_r <= cfg_data[3:0];
        REG_OUT_CHANNELS: noc_r <= cfg_data[3:0];
        REG_KERNEL_SIDE:  k_r <= cfg_data[2:0];
        REG_STRIDE:       s_r <= cfg_data[2:0];
        REG_PADDING:      p_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic q_full, q_ne, q_pop;
  in_item_t q_head;

  c2d_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(start && !q_full), .push_item(in_item),
    .pop(q_pop), .head_item(q_head), .not_empty(q_ne), .full(q_full)
  );

  assign busy = q_full;

  c2d_back #(
    .MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH), .MAX_DIM(MAX_DIM), .MAX_K(MAX_K)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .item_valid(q_ne), .item(q_head), .item_pop(q_pop),
    .h_cfg(h_r), .w_cfg(w_r), .nic_cfg(nic_r), .noc_cfg(noc_r), .k_cfg(k_r),
    .s_cfg(s_r), .p_cfg(p_r), .out_valid(out_valid), .out_item(out_item)
  );
endmodule
`default_nettype wire

// ----- tb/tb_conv2d_forward_engine.sv -----
// tb_conv2d_forward_engine: self-checking bench for the convolution engine
// depends on c2d_pkg and conv2d_forward_engine; predicts untyped compute items in-bench
`timescale 1ns / 1ps
module tb_conv2d_forward_engine;
  import c2d_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  conv2d_forward_engine u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [5:0]  regs [NUM_REGS];
  logic [15:0] samples [8][32][32];
  logic [15:0] weights [8][8][7][7];
  logic [31:0] biases [8];
  bit          smp_wr [8][32][32];
  bit          wgt_wr [8][8][7][7];
  bit          bias_wr [8];

  out_item_t   conv_expected [$];
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          idle_pct = 0;
  dir_row_t    dir_tab [$];

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int extent(int n, int p, int k, int s);
    if (n + 2 * p < k) return 0;
    return (n + 2 * p - k) / s + 1;
  endfunction

  function automatic out_item_t conv_predict(in_item_t it);
    out_item_t r;
    int h, w, nic, noc, k, s, p, ir, icl;
    longint acc, tot, a2;
    h   = clampi(regs[REG_IN_HEIGHT], 1, 32);
    w   = clampi(regs[REG_IN_WIDTH], 1, 32);
    nic = clampi(regs[REG_IN_CHANNELS], 1, 8);
    noc = clampi(regs[REG_OUT_CHANNELS], 1, 8);
    k   = clampi(regs[REG_KERNEL_SIDE], 1, 7);
    s   = clampi(regs[REG_STRIDE], 1, 4);
    p   = regs[REG_PADDING] & 3;
    r = '0;
    if (it.out_channel >= noc || it.row >= extent(h, p, k, s) || it.col >= extent(w, p, k, s)) begin
      r.status = 1'b1;
      return r;
    end
    acc = 0;
    for (int c = 0; c < nic; c++)
      for (int kr = 0; kr < k; kr++) begin
        ir = it.row * s + kr - p;
        if (ir < 0 || ir >= h) continue;
        for (int kc = 0; kc < k; kc++) begin
          icl = it.col * s + kc - p;
          if (icl < 0 || icl >= w) continue;
          acc += longint'($signed(samples[c][ir][icl]))
               * longint'($signed(weights[it.out_channel][c][kr][kc]));
        end
      end
    a2 = acc + 2048;
    tot = (a2 >>> 12) + longint'($signed(biases[it.out_channel]));
    if (tot > 64'sd2147483647) tot = 64'sd2147483647;
    if (tot < -64'sd2147483648) tot = -64'sd2147483648;
    r.conv_value = tot[31:0];
    return r;
  endfunction

  task automatic absorb(in_item_t it, bit typed, out_item_t want);
    case (opcode_t'(it.opcode))
      OP_LOAD_SAMPLE: begin
        samples[it.in_channel][it.row][it.col] = it.value[15:0];
        smp_wr[it.in_channel][it.row][it.col] = 1'b1;
      end
      OP_LOAD_WEIGHT: begin
        if (it.row < 7 && it.col < 7) begin
          weights[it.out_channel][it.in_channel][it.row][it.col] = it.value[15:0];
          wgt_wr[it.out_channel][it.in_channel][it.row][it.col] = 1'b1;
        end
      end
      OP_LOAD_BIAS: begin
        biases[it.out_channel] = it.value;
        bias_wr[it.out_channel] = 1'b1;
      end
      default: conv_expected.push_back(typed ? want : conv_predict(it));
    endcase
  endtask

  task automatic issue(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    absorb(it, typed, want);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [5:0] data);
    logic [5:0] m;
    case (idx)
      REG_IN_CHANNELS, REG_OUT_CHANNELS: m = 6'h0F;
      REG_KERNEL_SIDE, REG_STRIDE: m = 6'h07;
      REG_PADDING: m = 6'h03;
      default: m = 6'h3F;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx < NUM_REGS) regs[idx] = data & m;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (conv_expected.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return {16'($urandom_range(0, 65535)), 16'h7FFF};
      3: return {16'($urandom_range(0, 65535)), 16'h8000};
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t mk(opcode_t op, int oc, int ic, int r, int c, logic [31:0] v);
    in_item_t it;
    it.opcode = op;
    it.out_channel = 3'(oc);
    it.in_channel = 3'(ic);
    it.row = 5'(r);
    it.col = 5'(c);
    it.value = v;
    return it;
  endfunction

  task automatic add_row(in_item_t it, bit typed = 1'b0, logic [31:0] v = '0, bit st = 1'b0);
    dir_row_t d;
    d.item = it;
    d.typed = typed;
    d.want.conv_value = v;
    d.want.status = st;
    dir_tab.push_back(d);
  endtask

  // fill every entry the current setting can read that is still unwritten
  task automatic fill_stores();
    int h, w, nic, noc, k;
    h   = clampi(regs[REG_IN_HEIGHT], 1, 32);
    w   = clampi(regs[REG_IN_WIDTH], 1, 32);
    nic = clampi(regs[REG_IN_CHANNELS], 1, 8);
    noc = clampi(regs[REG_OUT_CHANNELS], 1, 8);
    k   = clampi(regs[REG_KERNEL_SIDE], 1, 7);
    for (int c = 0; c < nic; c++)
      for (int r = 0; r < h; r++)
        for (int q = 0; q < w; q++)
          if (!smp_wr[c][r][q]) issue(mk(OP_LOAD_SAMPLE, $urandom_range(0, 7), c, r, q, rand_val()));
    for (int o = 0; o < noc; o++) begin
      if (!bias_wr[o]) issue(mk(OP_LOAD_BIAS, o, $urandom_range(0, 7), $urandom_range(0, 31),
                                $urandom_range(0, 31), rand_val()));
      for (int c = 0; c < nic; c++)
        for (int r = 0; r < k; r++)
          for (int q = 0; q < k; q++)
            if (!wgt_wr[o][c][r][q]) issue(mk(OP_LOAD_WEIGHT, o, c, r, q, rand_val()));
    end
  endtask

  task automatic random_items(int n);
    int h, w, nic, noc, k, s, p, oh, ow, sel;
    in_item_t it;
    h   = clampi(regs[REG_IN_HEIGHT], 1, 32);
    w   = clampi(regs[REG_IN_WIDTH], 1, 32);
    nic = clampi(regs[REG_IN_CHANNELS], 1, 8);
    noc = clampi(regs[REG_OUT_CHANNELS], 1, 8);
    k   = clampi(regs[REG_KERNEL_SIDE], 1, 7);
    s   = clampi(regs[REG_STRIDE], 1, 4);
    p   = regs[REG_PADDING] & 3;
    oh  = clampi(extent(h, p, k, s), 0, 32);
    ow  = clampi(extent(w, p, k, s), 0, 32);
    for (int i = 0; i < n; i++) begin
      it = mk(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 31),
              $urandom_range(0, 31), $urandom);
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        it.opcode = OP_LOAD_SAMPLE;
        it.in_channel = 3'($urandom_range(0, nic - 1));
        it.row = 5'($urandom_range(0, h - 1));
        it.col = 5'($urandom_range(0, w - 1));
        it.value = rand_val();
      end else if (sel < 18) begin
        it.opcode = OP_LOAD_SAMPLE;
        it.value = rand_val();
      end else if (sel < 28) begin
        it.opcode = OP_LOAD_WEIGHT;
        it.out_channel = 3'($urandom_range(0, noc - 1));
        it.in_channel = 3'($urandom_range(0, nic - 1));
        it.row = 5'($urandom_range(0, k - 1));
        it.col = 5'($urandom_range(0, k - 1));
        it.value = rand_val();
      end else if (sel < 31) begin
        it.opcode = OP_LOAD_WEIGHT;
        it.value = rand_val();
      end else if (sel < 34) begin
        it.opcode = OP_LOAD_BIAS;
        it.value = rand_val();
      end else if (sel < 88 && oh > 0 && ow > 0) begin
        it.out_channel = 3'($urandom_range(0, noc - 1));
        it.row = 5'($urandom_range(0, oh - 1));
        it.col = 5'($urandom_range(0, ow - 1));
      end
      // writes that the setting may later read must keep the stores defined
      if (it.opcode == OP_LOAD_WEIGHT && it.row < 7 && it.col < 7 &&
          !wgt_wr[it.out_channel][it.in_channel][it.row][it.col])
        it.value = rand_val();
      issue(it);
    end
  endtask

  task automatic run_phase(int h, int w, int nic, int noc, int k, int s, int p, int mode);
    wait_idle();
    cfg_write(REG_IN_HEIGHT, 6'(h));
    cfg_write(REG_IN_WIDTH, 6'(w));
    cfg_write(REG_IN_CHANNELS, 6'(nic));
    cfg_write(REG_OUT_CHANNELS, 6'(noc));
    cfg_write(REG_KERNEL_SIDE, 6'(k));
    cfg_write(REG_STRIDE, 6'(s));
    cfg_write(REG_PADDING, 6'(p));
    cfg_we <= 1'b0;
    @(posedge clk);
    case (mode % 3)
      0: idle_pct = 0;
      1: idle_pct = 78;
      default: idle_pct = 35;
    endcase
    fill_stores();
    random_items(30);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (conv_expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h status %b", out_item.conv_value,
                                   out_item.status);
      end else begin
        if (out_item.conv_value !== conv_expected[0].conv_value ||
            out_item.status !== conv_expected[0].status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h/%b got %h/%b", conv_expected[0].conv_value,
                     conv_expected[0].status, out_item.conv_value, out_item.status);
        end
        void'(conv_expected.pop_front());
      end
    end
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

  initial begin
    regs[REG_IN_HEIGHT] = 6'd32;
    regs[REG_IN_WIDTH] = 6'd32;
    regs[REG_IN_CHANNELS] = 6'd1;
    regs[REG_OUT_CHANNELS] = 6'd1;
    regs[REG_KERNEL_SIDE] = 6'd3;
    regs[REG_STRIDE] = 6'd1;
    regs[REG_PADDING] = 6'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default setting: 32x32 plane, one channel, 3x3 kernel
    add_row(mk(OP_COMPUTE, 7, 0, 0, 0, 0), 1'b1, 32'd0, 1'b1);
    add_row(mk(OP_COMPUTE, 0, 0, 31, 0, 0), 1'b1, 32'd0, 1'b1);
    add_row(mk(OP_COMPUTE, 0, 0, 0, 30, 0), 1'b1, 32'd0, 1'b1);
    add_row(mk(OP_LOAD_WEIGHT, 0, 0, 7, 31, 32'h1234_5678));
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        add_row(mk(OP_LOAD_SAMPLE, 0, 0, r, c, 32'hABCD_8000));
        add_row(mk(OP_LOAD_SAMPLE, 0, 0, 29 + r, 29 + c, rand_val()));
        add_row(mk(OP_LOAD_WEIGHT, 0, 0, r, c, 32'h0001_8000));
      end
    add_row(mk(OP_LOAD_BIAS, 0, 0, 0, 0, 32'h7FFF_FFFF));
    add_row(mk(OP_COMPUTE, 0, 0, 0, 0, 0), 1'b1, 32'h7FFF_FFFF, 1'b0);
    add_row(mk(OP_COMPUTE, 0, 0, 29, 29, 0));
    foreach (dir_tab[i]) issue(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    wait_idle();
    cfg_write(3'd7, 6'h3F);
    run_phase(5, 6, 2, 3, 3, 2, 1, 0);
    run_phase(9, 8, 1, 1, 7, 4, 3, 1);
    run_phase(4, 4, 15, 2, 2, 1, 0, 2);
    run_phase(0, 63, 3, 0, 0, 7, 3, 0);
    run_phase(2, 2, 1, 2, 5, 1, 0, 1);
    run_phase(6, 3, 3, 2, 4, 3, 2, 2);
    run_phase(1, 1, 1, 1, 1, 1, 0, 1);
    run_phase(8, 7, 2, 2, 3, 1, 1, 0);
    wait_idle();

    $display("sent %0d items, checked %0d results over 9 register settings", items_sent,
             results_seen);
    $display("%0d mismatches", errors);
    if (errors == 0 && conv_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/c2d_pkg.sv
sv/c2d_queue.sv
sv/c2d_back.sv
sv/conv2d_forward_engine.sv
tb/tb_conv2d_forward_engine.sv
